// ===== hw/rtl/f2f8_pkg.sv =====
// Shared types and constants for the fp32 to fp8 FNUZ converter.
`default_nettype none

package f2f8_pkg;

  typedef enum logic {
    FMT_E4M3 = 1'b0,
    FMT_E5M2 = 1'b1
  } f2f8_fmt_e;

  localparam int unsigned FP32_W     = 32;
  localparam int unsigned FP8_W      = 8;
  localparam int unsigned FP32_MAN_W = 23;

  localparam logic [7:0] FP32_EXP_ONES = 8'hFF;
  localparam logic [7:0] FP8_NAN_CODE  = 8'h80;

endpackage

`default_nettype wire

// ===== hw/rtl/f2f8_if.sv =====
// Valid/ready stream interfaces for the converter input and result channels.
`default_nettype none

interface f2f8_in_if;
  logic                               valid;
  logic                               ready;
  logic [f2f8_pkg::FP32_W-1:0]        float_bits;

  modport source (output valid, output float_bits, input ready);
  modport sink   (input valid, input float_bits, output ready);
endinterface

interface f2f8_out_if;
  logic                               valid;
  logic                               ready;
  logic [f2f8_pkg::FP8_W-1:0]         fp8_value;

  modport source (output valid, output fp8_value, input ready);
  modport sink   (input valid, input fp8_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/f2f8_conv.sv =====
// Combinational fp32 to fp8 FNUZ conversion with round-to-nearest-even and saturation.
`default_nettype none

module f2f8_conv (
  input  wire logic [f2f8_pkg::FP32_W-1:0] float_bits_i,
  input  wire f2f8_pkg::f2f8_fmt_e         fmt_i,
  output logic [f2f8_pkg::FP8_W-1:0]       fp8_value_o
);

  logic        sign;
  logic [7:0]  bexp;
  logic [23:0] sig;
  logic [4:0]  drop;
  logic [7:0]  bias_off;
  logic [7:0]  den_lim;
  logic [7:0]  max_exp;
  logic [6:0]  diff;
  logic [4:0]  s_amt;
  logic [31:0] tie_mask;
  logic [31:0] tie_half;
  logic        mid;
  logic [23:0] shifted;
  logic [23:0] rnd_mask;
  logic        odd;
  logic [23:0] addend;
  logic [24:0] sum;
  logic [7:0]  exp0;
  logic [7:0]  exp1;
  logic [24:0] m1;
  logic [24:0] mq;

  always_comb begin
    sign = float_bits_i[31];
    bexp = float_bits_i[30:23];
    sig  = {1'b1, float_bits_i[f2f8_pkg::FP32_MAN_W-1:0]};

    if (fmt_i == f2f8_pkg::FMT_E5M2) begin
      drop     = 5'd21;
      bias_off = 8'd111;
      den_lim  = 8'd112;
      max_exp  = 8'd31;
    end else begin
      drop     = 5'd20;
      bias_off = 8'd119;
      den_lim  = 8'd120;
      max_exp  = 8'd15;
    end

    // Distance below the smallest normal exponent
    if (bexp <= den_lim) begin
      diff = 7'(den_lim - bexp);
    end else begin
      diff = 7'd0;
    end

    // Tie is judged on the unshifted significand; large shifts can never tie
    s_amt    = drop + {2'b00, diff[2:0]};
    tie_mask = (32'd1 << s_amt) - 32'd1;
    tie_half = 32'd1 << (s_amt - 5'd1);
    mid      = (diff[6:3] == 4'd0) && (({8'd0, sig} & tie_mask) == tie_half);

    shifted = sig >> diff;
    exp0    = (diff != 7'd0) ? 8'd0 : 8'(bexp - bias_off);

    rnd_mask = (24'd1 << drop) - 24'd1;
    odd      = shifted[drop];
    addend   = (mid && !odd) ? ((shifted - 24'd1) & rnd_mask) : (shifted & rnd_mask);
    sum      = {1'b0, shifted} + {1'b0, addend};

    // Carry out of rounding: denormal becomes smallest normal, normal bumps exponent
    if ((exp0 == 8'd0) && sum[23]) begin
      exp1 = 8'd1;
      m1   = sum;
    end else if (sum[24]) begin
      exp1 = exp0 + 8'd1;
      m1   = sum >> 1;
    end else begin
      exp1 = exp0;
      m1   = sum;
    end

    mq = m1 >> drop;

    if ((float_bits_i[30:23] & f2f8_pkg::FP32_EXP_ONES) == f2f8_pkg::FP32_EXP_ONES) begin
      fp8_value_o = f2f8_pkg::FP8_NAN_CODE;
    end else if (bexp == 8'd0) begin
      fp8_value_o = 8'd0;
    end else if (exp1 > max_exp) begin
      fp8_value_o = {sign, 7'h7F};
    end else if ((exp1 == 8'd0) && (mq == 25'd0)) begin
      fp8_value_o = 8'd0;
    end else if (fmt_i == f2f8_pkg::FMT_E5M2) begin
      fp8_value_o = {sign, exp1[4:0], mq[1:0]};
    end else begin
      fp8_value_o = {sign, exp1[3:0], mq[2:0]};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fp32_to_fp8_fnuz_convert.sv =====
// Beats pass the input register, then the result register. Throughput: one beat
// per cycle while the sink is ready; the input register feeds the converter logic
// and the result register holds its output, so a beat enters while a result waits.
// Reset (rst_ni low, asynchronous): both stage valids clear, format_select goes to
// E4M3 FNUZ. Payload registers are not reset.
`default_nettype none

module fp32_to_fp8_fnuz_convert (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  f2f8_in_if.sink          in_i,
  f2f8_out_if.source       out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Register index of format_select in the register map
  localparam logic REG_FORMAT_SELECT = 1'b0;

  f2f8_pkg::f2f8_fmt_e fmt_q;

  logic                            s0_valid_q;
  logic [f2f8_pkg::FP32_W-1:0]     s0_bits_q;
  logic                            s0_ready;

  logic                            out_valid_q;
  logic [f2f8_pkg::FP8_W-1:0]      out_value_q;
  logic [f2f8_pkg::FP8_W-1:0]      res_d;
  logic                            s1_ready;

  logic                            cfg_wr;

  // ---------------------------------------------------------------------------
  // Configuration port: single register, zero wait states
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FORMAT_SELECT);
  assign prdata = (paddr[2] == REG_FORMAT_SELECT) ? {31'd0, fmt_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= f2f8_pkg::FMT_E4M3;
    end else if (cfg_wr) begin
      fmt_q <= f2f8_pkg::f2f8_fmt_e'(pwdata[0]);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: each stage advances when it is empty or its successor advances
  // ---------------------------------------------------------------------------
  assign s1_ready   = !out_valid_q || out_o.ready;
  assign s0_ready   = !s0_valid_q || s1_ready;
  assign in_i.ready = s0_ready;

  // Input register: capture the raw fp32 pattern of each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && s0_ready) begin
      s0_bits_q <= in_i.float_bits;
    end
  end

  // Conversion between the input register and the result register
  f2f8_conv u_conv (
    .float_bits_i (s0_bits_q),
    .fmt_i        (fmt_q),
    .fp8_value_o  (res_d)
  );

  // Result register: hold the byte until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_ready) begin
      out_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_valid_q && s1_ready) begin
      out_value_q <= res_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.fp8_value = out_value_q;

`ifndef SYNTHESIS
  // A new result appears only behind a beat that sat in the input register
  a_res_from_s0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s0_valid_q))
    else $error("result valid without a staged input beat");

  // Infinity and NaN inputs always convert to the NaN code
  a_nan_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_valid_q && (s0_bits_q[30:23] == f2f8_pkg::FP32_EXP_ONES))
      |-> (res_d == f2f8_pkg::FP8_NAN_CODE))
    else $error("non-finite input did not give the NaN code");

  // The NaN code is never produced from a finite input (no negative zero)
  a_no_neg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_valid_q && (res_d == f2f8_pkg::FP8_NAN_CODE))
      |-> (s0_bits_q[30:23] == f2f8_pkg::FP32_EXP_ONES))
    else $error("finite input produced the NaN code");

  // A stalled result keeps its byte while a new beat waits in the input register
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready && s0_valid_q) |=> $stable(out_value_q))
    else $error("result register overwritten during a stall");
`endif

endmodule

`default_nettype wire
